>>> src/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg: shared types and constants for the grid peak finder
// Payload structs for the cell and peak channels, grid limits and register
// indexes of the configuration port.
// ----------------------------------------------------------------------------
package gpf_pkg;

    localparam int ELEV_BITS = 16;
    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 1024;

    localparam int COL_W     = $clog2(MAX_COLS);      // column index
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);  // row counter, may hold MAX_ROWS
    localparam int NCOL_W    = $clog2(MAX_COLS + 1);  // column count, may hold MAX_COLS

    localparam int ROWS_REG_W = 11;
    localparam int COLS_REG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    localparam logic [ROWS_REG_W-1:0] NUM_ROWS_RESET = 11'd20;
    localparam logic [COLS_REG_W-1:0] NUM_COLS_RESET = 7'd20;

    typedef logic signed [ELEV_BITS-1:0] gpf_elev_t;

    typedef struct packed {
        gpf_elev_t elevation;
        logic      flush;
    } gpf_item_t;

    typedef struct packed {
        logic [9:0] peak_row;
        logic [5:0] peak_col;
    } gpf_peak_t;

    // One line-store word: the column's cell in the previous row and the row before it
    typedef struct packed {
        gpf_elev_t prev;
        gpf_elev_t prev2;
    } gpf_word_t;

endpackage

>>> src/grid_peak_finder.sv
// ----------------------------------------------------------------------------
// grid_peak_finder: streaming 4-neighbour local-maximum detector
// Reports every grid cell that no in-grid up, down, left or right neighbour
// exceeds, in row-major order.
// ----------------------------------------------------------------------------
// Cells arrive in raster order on the item channel, one beat per cell; after
// the last row, num_cols beats with flush set decide the final row, and the
// position counters then restart for the next frame. A cell is decided when
// the cell below it arrives, so each beat yields at most one peak beat. The
// block takes one beat per clock, and a peak leaves in the cycle after the
// beat that decides it. A line store of MAX_COLS words, each holding a
// column's last two rows, is written at the current column and read two
// columns ahead in the same cycle, so the decision needs only registers and
// four compares. A one-deep result register holds the peak; input stalls
// only while a held peak is refused. The line store needs no clearing after
// reset. A write to either configuration register restarts the frame; write
// only while the block is idle. A flush beat before the last row and a data
// beat while flush beats are due are taken and dropped.
module grid_peak_finder
    import gpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  gpf_item_t             item,
    output logic                  peak_valid,
    input  logic                  peak_ready,
    output gpf_peak_t             peak,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Control state
    logic [ROW_W-1:0]  rows_reg, rows_next;
    logic [NCOL_W-1:0] cols_reg, cols_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              out_valid_reg, out_valid_next;
    logic              byp_reg;

    // Payload and window registers
    gpf_peak_t         out_reg;
    gpf_word_t         cur_reg;
    gpf_word_t         rd_reg;
    gpf_word_t         fwd_reg;
    gpf_elev_t         left_reg;
    gpf_word_t         mem [MAX_COLS];

    logic              accept;
    logic              data_step;
    logic              flush_step;
    logic              step;
    logic [NCOL_W-1:0] col_inc;
    logic [COL_W-1:0]  col_adv;
    logic [NCOL_W-1:0] ahead_inc;
    logic [COL_W-1:0]  ahead_addr;
    logic [ROW_W-1:0]  row_dec;
    gpf_word_t         ahead;
    gpf_word_t         post;
    gpf_word_t         cur_next;
    gpf_elev_t         mid;
    logic              peak_hit;
    logic              emit;
    logic [ROWS_REG_W-1:0] cfg_rows;
    logic [COLS_REG_W-1:0] cfg_cols;

    assign cfg_ready  = 1'b1;
    assign item_ready = !out_valid_reg || peak_ready;
    assign accept     = item_valid && item_ready;
    assign peak_valid = out_valid_reg;
    assign peak       = out_reg;

    assign data_step  = accept && !item.flush && (row_reg < rows_reg);
    assign flush_step = accept && item.flush && (row_reg >= rows_reg);
    assign step       = data_step || flush_step;

    // Next column and the column after it, both cyclic over the row
    assign col_inc    = NCOL_W'(col_reg) + NCOL_W'(1);
    assign col_adv    = (col_inc == cols_reg) ? '0 : col_inc[COL_W-1:0];
    assign ahead_inc  = NCOL_W'(col_adv) + NCOL_W'(1);
    assign ahead_addr = (ahead_inc == cols_reg) ? '0 : ahead_inc[COL_W-1:0];

    assign ahead    = byp_reg ? fwd_reg : rd_reg;
    assign post     = data_step ? gpf_word_t'{prev: item.elevation, prev2: cur_reg.prev}
                                : cur_reg;
    assign cur_next = (col_adv == col_reg) ? post : ahead;

    // Decide the cell one row up; in the flush phase the row counter equals rows
    assign row_dec  = row_reg - ROW_W'(1);
    assign mid      = cur_reg.prev;
    assign peak_hit = !((row_reg > ROW_W'(1)) && (cur_reg.prev2 > mid))
                   && !(data_step && (item.elevation > mid))
                   && !((col_reg != '0) && (left_reg > mid))
                   && !((col_inc < cols_reg) && (ahead.prev > mid));
    assign emit     = step && (row_reg != '0) && peak_hit;

    assign cfg_rows = cfg_data[ROWS_REG_W-1:0];
    assign cfg_cols = cfg_data[COLS_REG_W-1:0];

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;

        if (peak_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end

        if (step)
        begin
            col_next = col_adv;
            if (col_adv == '0)
            begin
                row_next = data_step ? row_reg + ROW_W'(1) : '0;
            end
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:
                begin
                    if (cfg_rows == '0)
                        rows_next = ROW_W'(1);
                    else if (ROW_W'(cfg_rows) > ROW_W'(MAX_ROWS))
                        rows_next = ROW_W'(MAX_ROWS);
                    else
                        rows_next = ROW_W'(cfg_rows);
                    row_next = '0;
                    col_next = '0;
                end
                REG_NUM_COLS:
                begin
                    if (cfg_cols == '0)
                        cols_next = NCOL_W'(1);
                    else if (cfg_cols > COLS_REG_W'(MAX_COLS))
                        cols_next = NCOL_W'(MAX_COLS);
                    else
                        cols_next = NCOL_W'(cfg_cols);
                    row_next = '0;
                    col_next = '0;
                end
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROW_W'(NUM_ROWS_RESET);
            cols_reg      <= NCOL_W'(NUM_COLS_RESET);
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                byp_reg <= (ahead_addr == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.peak_row <= row_dec[9:0];
            out_reg.peak_col <= col_reg;
        end
        if (step)
        begin
            cur_reg  <= cur_next;
            fwd_reg  <= post;
            left_reg <= cur_reg.prev;
        end
    end

    // Line store: write this column, fetch two columns ahead
    always_ff @(posedge clk)
    begin
        if (data_step)
        begin
            mem[col_reg] <= post;
        end
        if (step)
        begin
            rd_reg <= mem[ahead_addr];
        end
    end

`ifndef SYNTH
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        NCOL_W'(col_reg) < cols_reg)
        else $error("column counter beyond row width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= rows_reg)
        else $error("row counter beyond frame");

    a_peak_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(item_valid && item_ready))
        else $error("peak raised without an input beat");

    a_peak_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ROW_W'(out_reg.peak_row) < rows_reg))
        else $error("peak row outside frame");
`endif

endmodule
